/* rtl/tach_pkg.sv */
// Shared types and constants for the edge-period tachometer.
// No dependencies; imported by tach_div, the top level and the testbench.
`default_nettype none

package tach_pkg;

    localparam int RPM_W  = 16;   // rpm result width
    localparam int CPR_W  = 7;    // changes-per-rotation register width
    localparam int TO_W   = 16;   // stop timeout register width
    localparam int PROD_W = CPR_W + RPM_W;   // divisor width: cpr * elapsed

    localparam logic [RPM_W-1:0] RPM_NUM = 16'd60000;

    localparam logic [TO_W-1:0]  TIMEOUT_RST = 16'd1500;
    localparam logic [CPR_W-1:0] CPR_RST     = 7'd4;

    typedef logic [RPM_W-1:0] rpm_t;
    typedef logic [CPR_W-1:0] cpr_t;
    typedef logic [1:0]       event_t;

    localparam event_t EV_NONE    = 2'd0;
    localparam event_t EV_STARTED = 2'd1;
    localparam event_t EV_STOPPED = 2'd2;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_CPR     = 1'b1;

endpackage

`default_nettype wire

/* rtl/tach_div.sv */
// Serial rpm unit: shift-add multiply of cpr by elapsed, then restoring divide of 60000.
// Depends on tach_pkg.
`default_nettype none

module tach_div
    import tach_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  start,
    input  cpr_t cpr,
    input  rpm_t elapsed,
    output logic done,
    output rpm_t quotient
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]        state_reg;
    logic [3:0]        cnt_reg;
    logic [CPR_W-1:0]  mc_sr_reg;
    logic [PROD_W-1:0] md_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W:0]   rem_reg;
    logic [RPM_W-1:0]  num_sr_reg;
    rpm_t              quot_reg;
    logic              done_reg;

    logic [PROD_W:0]   rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg[PROD_W-1:0], num_sr_reg[RPM_W-1]};
    assign fits      = rem_shift >= {1'b0, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_MUL;
                        cnt_reg   <= '0;
                    end
                end
                ST_MUL:
                begin
                    if (cnt_reg == 4'(CPR_W - 1))
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == 4'(RPM_W - 1))
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // a zero count acts as one
                    mc_sr_reg  <= (cpr == '0) ? CPR_W'(1) : cpr;
                    md_reg     <= PROD_W'(elapsed);
                    prod_reg   <= '0;
                    rem_reg    <= '0;
                    num_sr_reg <= RPM_NUM;
                end
            end
            ST_MUL:
            begin
                if (mc_sr_reg[0])
                begin
                    prod_reg <= prod_reg + md_reg;
                end
                md_reg    <= {md_reg[PROD_W-2:0], 1'b0};
                mc_sr_reg <= {1'b0, mc_sr_reg[CPR_W-1:1]};
            end
            ST_DIV:
            begin
                rem_reg    <= fits ? (rem_shift - {1'b0, prod_reg}) : rem_shift;
                quot_reg   <= {quot_reg[RPM_W-2:0], fits};
                num_sr_reg <= {num_sr_reg[RPM_W-2:0], 1'b0};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

/* rtl/tachometer_rpm_with_stop_timeout_top.sv */
// Edge-period tachometer with stop timeout: top level, control and bit-serial time path.
// Depends on tach_pkg and tach_div.
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    s_tdata: pin_level, now_ms (one sample)
// m_*      out  m_tvalid/m_tready    m_tdata: rpm, moving, event_res
// cfg_*    in   cfg_we               cfg_index 0 stop timeout, 1 edges per turn
//
// The result is registered after the serial subtract and the decide step and, when an
// rpm value is computed, after the divider's 7 multiply steps and 16 divide steps and
// the hand-over of the quotient; no new item is taken until the result has gone to the
// output register. The first sample after reset skips the subtract and goes straight to
// the finish step. The elapsed-time subtract and both compares run one bit per cycle.
// Reset clears the control state and the config registers; no clearing pass. A held
// output item stalls the next result but the next sample is still taken in.
`default_nettype none

module tachometer_rpm_with_stop_timeout_top
    import tach_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,     // [0] pin_level, [32:1] now_ms, rest zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,     // [15:0] rpm, [16] moving, [18:17] event_res
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data
);

    localparam int CNT_W  = $clog2(TIME_BITS);
    localparam int WIDE_W = TIME_BITS + 32;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SUB    = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]           state_reg;
    logic [CNT_W-1:0]     bit_cnt_reg;
    logic [TIME_BITS-1:0] now_sr_reg;
    logic [TIME_BITS-1:0] lct_reg;
    logic [TIME_BITS-1:0] el_sr_reg;
    logic [TO_W-1:0]      to_sr_reg;
    logic [RPM_W-1:0]     k_sr_reg;
    logic                 carry_reg;
    logic                 ge_reg;
    logic                 gt_reg;
    logic                 nz_reg;
    logic                 level_reg;
    logic                 primed_reg;
    logic                 last_level_reg;
    logic                 rotating_reg;
    rpm_t                 rpm_reg;
    event_t               event_reg;
    logic [TO_W-1:0]      timeout_reg;
    cpr_t                 cpr_reg;
    logic                 out_valid_reg;
    rpm_t                 out_rpm_reg;
    logic                 out_moving_reg;
    event_t               out_event_reg;

    logic [WIDE_W-1:0]    now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic                 d_bit;
    logic                 carry_next;
    logic                 ge_next;
    logic                 gt_next;
    logic                 accept;
    logic                 change;
    logic                 out_free;
    logic                 div_start;
    logic                 div_done;
    rpm_t                 div_quot;
    rpm_t                 div_elapsed;

    assign now_wide = {{TIME_BITS{1'b0}}, s_tdata[32:1]};
    assign now_t    = now_wide[TIME_BITS-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign change   = level_reg != last_level_reg;

    // now - last as now + ~last + 1, LSB first
    assign d_bit      = now_sr_reg[0] ^ ~lct_reg[0] ^ carry_reg;
    assign carry_next = (now_sr_reg[0] & ~lct_reg[0])
                      | (carry_reg & (now_sr_reg[0] ^ ~lct_reg[0]));
    assign ge_next    = (d_bit & ~to_sr_reg[0]) | (ge_reg & ~(d_bit ^ to_sr_reg[0]));
    assign gt_next    = (d_bit & ~k_sr_reg[0]) | (gt_reg & ~(d_bit ^ k_sr_reg[0]));

    assign div_start   = (state_reg == ST_DECIDE) && change && rotating_reg && !gt_reg;
    // a zero interval counts as one millisecond
    assign div_elapsed = nz_reg ? el_sr_reg[RPM_W-1:0] : RPM_W'(1);

    tach_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .cpr      (cpr_reg),
        .elapsed  (div_elapsed),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            cpr_reg     <= CPR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data[TO_W-1:0];
                REG_CPR:     cpr_reg     <= cfg_data[CPR_W-1:0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            primed_reg     <= 1'b0;
            last_level_reg <= 1'b0;
            lct_reg        <= '0;
            rotating_reg   <= 1'b0;
            rpm_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!primed_reg)
                        begin
                            primed_reg     <= 1'b1;
                            last_level_reg <= s_tdata[0];
                            lct_reg        <= now_t;
                            state_reg      <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_SUB;
                        end
                    end
                end
                ST_SUB:
                begin
                    // rotate so the stored time is intact after the last bit
                    lct_reg <= {lct_reg[0], lct_reg[TIME_BITS-1:1]};
                    if (bit_cnt_reg == CNT_W'(TIME_BITS - 1))
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    state_reg <= div_start ? ST_DIV : ST_FINISH;
                    if (change)
                    begin
                        // over 60000 ms the rate rounds down to zero
                        if (rotating_reg && gt_reg)
                        begin
                            rpm_reg <= '0;
                        end
                        rotating_reg   <= 1'b1;
                        lct_reg        <= now_sr_reg;
                        last_level_reg <= level_reg;
                    end
                    else if (rotating_reg && ge_reg)
                    begin
                        rotating_reg <= 1'b0;
                        rpm_reg      <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        rpm_reg   <= div_quot;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath: shift registers and flags
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    level_reg   <= s_tdata[0];
                    now_sr_reg  <= now_t;
                    to_sr_reg   <= timeout_reg;
                    k_sr_reg    <= RPM_NUM;
                    bit_cnt_reg <= '0;
                    carry_reg   <= 1'b1;
                    ge_reg      <= 1'b1;
                    gt_reg      <= 1'b0;
                    nz_reg      <= 1'b0;
                    event_reg   <= EV_NONE;
                end
            end
            ST_SUB:
            begin
                now_sr_reg  <= {now_sr_reg[0], now_sr_reg[TIME_BITS-1:1]};
                el_sr_reg   <= {d_bit, el_sr_reg[TIME_BITS-1:1]};
                to_sr_reg   <= {1'b0, to_sr_reg[TO_W-1:1]};
                k_sr_reg    <= {1'b0, k_sr_reg[RPM_W-1:1]};
                carry_reg   <= carry_next;
                ge_reg      <= ge_next;
                gt_reg      <= gt_next;
                nz_reg      <= nz_reg | d_bit;
                bit_cnt_reg <= bit_cnt_reg + CNT_W'(1);
            end
            ST_DECIDE:
            begin
                if (change)
                begin
                    event_reg <= rotating_reg ? EV_NONE : EV_STARTED;
                end
                else if (rotating_reg && ge_reg)
                begin
                    event_reg <= EV_STOPPED;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_rpm_reg    <= rpm_reg;
                    out_moving_reg <= rotating_reg;
                    out_event_reg  <= event_reg;
                end
            end
            default:
            begin
                level_reg <= level_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_event_reg, out_moving_reg, out_rpm_reg};

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for the edge-period tachometer: drives timestamped pin samples and
// register writes, predicts every reading and checks each one as it leaves the block.
// Depends on tach_pkg and tachometer_rpm_with_stop_timeout_top.
`timescale 1ns / 100ps

module tb;
    import tach_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 210;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        event_t ev;
        logic   moving;
        rpm_t   rpm;
    } reading_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        reg_idx;
        logic [15:0] reg_val;
        logic        pin;
        logic [31:0] stamp;
        logic        typed;
        reading_t    want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [0] pin_level, [32:1] now_ms, [39:33] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [15:0] rpm, [16] moving, [18:17] event_res, [23:19] zero
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // predictor state and its copy of the registers
    logic        primed_q;
    logic        level_q;
    logic [31:0] edge_ms_q;
    logic        spinning_q;
    rpm_t        rpm_q;
    logic [15:0] timeout_q;
    cpr_t        cpr_q;

    reading_t    pending_readings[$];
    int          mismatches;
    int          cycles;
    bit          steady;

    tachometer_rpm_with_stop_timeout_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rpm_t rpm_from_interval(input logic [31:0] interval);
        logic [63:0] span;
        logic [63:0] per_turn;
        span     = (interval == 32'd0) ? 64'd1 : {32'd0, interval};
        per_turn = (cpr_q == '0) ? 64'd1 : {57'd0, cpr_q};
        if (span > {48'd0, RPM_NUM})
            return '0;
        return rpm_t'({48'd0, RPM_NUM} / (per_turn * span));
    endfunction

    function automatic reading_t predict_reading(input logic pin, input logic [31:0] stamp);
        logic [31:0] interval;
        reading_t    r;
        interval = stamp - edge_ms_q;
        r        = '0;
        r.ev     = EV_NONE;
        if (!primed_q)
        begin
            primed_q  = 1'b1;
            level_q   = pin;
            edge_ms_q = stamp;
        end
        else if (pin != level_q)
        begin
            if (spinning_q)
                rpm_q = rpm_from_interval(interval);
            else
                r.ev = EV_STARTED;
            spinning_q = 1'b1;
            edge_ms_q  = stamp;
            level_q    = pin;
        end
        else if (spinning_q && interval >= {16'd0, timeout_q})
        begin
            r.ev       = EV_STOPPED;
            spinning_q = 1'b0;
            rpm_q      = '0;
        end
        r.rpm    = rpm_q;
        r.moving = spinning_q;
        return r;
    endfunction

    // mostly back-to-back or short, now and then a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 40);
        if (r < 90)
            return $urandom_range(41, 1500);
        if (r < 97)
            return $urandom_range(1501, 70000);
        return $urandom_range(59999, 60001);
    endfunction

    function automatic dir_row_t known_row(input logic pin, input logic [31:0] stamp,
                                           input rpm_t rpm, input logic moving,
                                           input event_t ev);
        dir_row_t row;
        row             = '0;
        row.kind        = ROW_SAMPLE;
        row.pin         = pin;
        row.stamp       = stamp;
        row.typed       = 1'b1;
        row.want.rpm    = rpm;
        row.want.moving = moving;
        row.want.ev     = ev;
        return row;
    endfunction

    function automatic dir_row_t checked_row(input logic pin, input logic [31:0] stamp);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_SAMPLE;
        row.pin   = pin;
        row.stamp = stamp;
        return row;
    endfunction

    function automatic dir_row_t write_row(input logic idx, input logic [15:0] val);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic send_sample(input logic pin, input logic [31:0] stamp,
                               input logic typed, input reading_t want);
        int       gap;
        reading_t guess;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, stamp, pin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        guess = predict_reading(pin, stamp);
        pending_readings.push_back(typed ? want : guess);
    endtask

    // hold the input side and wait until every reading has been taken
    task automatic drain_readings();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_TIMEOUT)
            timeout_q = val;
        else
            cpr_q = val[CPR_W-1:0];
    endtask

    initial
    begin : reading_monitor
        int       stall_left;
        reading_t want;
        reading_t got;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = reading_t'(m_tdata[18:0]);
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected reading: rpm %0d moving %0b event %0d",
                             $time, got.rpm, got.moving, got.ev);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.rpm !== want.rpm)
                    begin
                        mismatches++;
                        $display("%0t: rpm mismatch: expected %0d, got %0d",
                                 $time, want.rpm, got.rpm);
                    end
                    if (got.moving !== want.moving)
                    begin
                        mismatches++;
                        $display("%0t: moving mismatch: expected %0b, got %0b",
                                 $time, want.moving, got.moving);
                    end
                    if (got.ev !== want.ev)
                    begin
                        mismatches++;
                        $display("%0t: event mismatch: expected %0d, got %0d",
                                 $time, want.ev, got.ev);
                    end
                end
            end
            if (stall_left == 0 && !steady && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
            m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** tachometer_rpm_with_stop_timeout_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t    rows[$];
        int          ph;
        int          n;
        int          pick;
        logic        pin;
        logic [31:0] cur_ms;
        logic [15:0] to_val;
        cpr_t        cpr_val;
        logic [8:0]  junk;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_TIMEOUT;
        cfg_data   = '0;
        steady     = 1'b0;
        mismatches = 0;
        primed_q   = 1'b0;
        level_q    = 1'b0;
        edge_ms_q  = '0;
        spinning_q = 1'b0;
        rpm_q      = '0;
        timeout_q  = TIMEOUT_RST;
        cpr_q      = CPR_RST;

        // directed part, reset settings: 1500 ms timeout, 4 changes per turn
        rows.push_back(known_row(1'b0, 32'd1000, 16'd0, 1'b0, EV_NONE));   // first sample
        rows.push_back(known_row(1'b0, 32'd1010, 16'd0, 1'b0, EV_NONE));
        rows.push_back(known_row(1'b1, 32'd1020, 16'd0, 1'b1, EV_STARTED));
        rows.push_back(known_row(1'b0, 32'd1020, 16'd15000, 1'b1, EV_NONE)); // zero interval
        rows.push_back(checked_row(1'b1, 32'd1030));
        rows.push_back(checked_row(1'b1, 32'd2529));                         // one short of stop
        rows.push_back(known_row(1'b1, 32'd2530, 16'd0, 1'b0, EV_STOPPED));
        rows.push_back(known_row(1'b1, 32'd2531, 16'd0, 1'b0, EV_NONE));
        rows.push_back(known_row(1'b0, 32'hFFFF_FFF0, 16'd0, 1'b1, EV_STARTED));
        rows.push_back(checked_row(1'b1, 32'h0000_0010));                    // wraps
        rows.push_back(known_row(1'b0, 32'h0000_EA71, 16'd0, 1'b1, EV_NONE)); // long interval
        rows.push_back(checked_row(1'b1, 32'h0001_D4D1));
        rows.push_back(write_row(REG_CPR, 16'd1));
        rows.push_back(known_row(1'b0, 32'h0001_D4D2, 16'd60000, 1'b1, EV_NONE));
        rows.push_back(write_row(REG_CPR, 16'd0));                           // counts as one
        rows.push_back(known_row(1'b1, 32'h0001_D4D3, 16'd60000, 1'b1, EV_NONE));
        rows.push_back(write_row(REG_CPR, 16'd127));
        rows.push_back(checked_row(1'b0, 32'h0001_D4D4));
        rows.push_back(write_row(REG_TIMEOUT, 16'd0));                       // zero timeout
        rows.push_back(known_row(1'b0, 32'h0001_D4D4, 16'd0, 1'b0, EV_STOPPED));
        rows.push_back(write_row(REG_TIMEOUT, 16'd65535));
        rows.push_back(write_row(REG_CPR, 16'd64));
        rows.push_back(known_row(1'b1, 32'h0001_D4D4, 16'd0, 1'b1, EV_STARTED));
        rows.push_back(checked_row(1'b1, 32'h0002_D4D2));
        rows.push_back(known_row(1'b1, 32'h0002_D4D3, 16'd0, 1'b0, EV_STOPPED));
        rows.push_back(known_row(1'b0, 32'hFFFF_FFFF, 16'd0, 1'b1, EV_STARTED));
        rows.push_back(checked_row(1'b1, 32'h0000_0000));
        rows.push_back(known_row(1'b0, 32'hFFFF_FFF0, 16'd0, 1'b1, EV_NONE)); // time ran back

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_WRITE)
            begin
                drain_readings();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end
            else
                send_sample(rows[i].pin, rows[i].stamp, rows[i].typed, rows[i].want);
        end

        pin    = 1'b0;
        cur_ms = 32'hFFFF_FFF0;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_readings();
            case (ph)
                0:
                begin
                    to_val  = TIMEOUT_RST;
                    cpr_val = CPR_RST;
                end
                1:
                begin
                    to_val  = 16'd1;
                    cpr_val = 7'd1;
                end
                2:
                begin
                    to_val  = 16'd65535;
                    cpr_val = 7'd64;
                end
                3:
                begin
                    to_val  = 16'd0;
                    cpr_val = 7'd0;
                end
                4:
                begin
                    to_val  = 16'd200;
                    cpr_val = 7'd127;
                end
                default:
                begin
                    to_val  = 16'($urandom_range(20, 3000));
                    cpr_val = 7'($urandom_range(1, 64));
                end
            endcase
            junk = 9'($urandom_range(0, 511));
            write_reg(REG_TIMEOUT, to_val);
            write_reg(REG_CPR, {junk, cpr_val});
            if (ph % 2 == 1)
                cur_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    pin    = !pin;
                    cur_ms = cur_ms + pick_interval();
                end
                else if (pick < 75)
                    cur_ms = cur_ms + pick_interval();
                else if (pick < 87)
                    // land just around the stop threshold
                    cur_ms = edge_ms_q + {16'd0, timeout_q} - 32'd2 + $urandom_range(0, 4);
                else if (pick < 94)
                begin
                    cur_ms = $urandom();
                    pin    = 1'($urandom_range(0, 1));
                end
                else
                begin
                    cur_ms = cur_ms - $urandom_range(1, 100);
                    pin    = 1'($urandom_range(0, 1));
                end
                send_sample(pin, cur_ms, 1'b0, '0);
            end
        end

        steady = 1'b0;
        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** tachometer_rpm_with_stop_timeout_top: PASSED **");
        else
            $display("** tachometer_rpm_with_stop_timeout_top: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tach_pkg.sv
rtl/tach_div.sv
rtl/tachometer_rpm_with_stop_timeout_top.sv
dv/tb.sv
